// File: rtl/cgla_pkg.sv
// ----------------------------------------------------------------------------
// cgla_pkg
// shared constants for the commit graph lane assigner
// ----------------------------------------------------------------------------
`default_nettype none

package cgla_pkg;

    localparam int LANES_DEF     = 32;
    localparam int MAX_PARENTS   = 4;
    localparam int PARENT_FIELDS = 4;
    localparam int KEY_W         = 64;
    localparam int LANE_OUT_W    = 5;
    localparam int COUNT_W       = 3;
    localparam int LANE_CNT_W    = 6;
    localparam int MASK_W        = 32;

endpackage

`default_nettype wire

// File: rtl/commit_graph_lane_assigner.sv
// ----------------------------------------------------------------------------
// commit_graph_lane_assigner
// assigns display lanes to commits and their parents from a lane key table
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_ready  | first_commit, commit_key, parents
// output  | out       | o_valid / i_ready  | lanes, masks, lane_count, overflow
//
// a transaction passes through an idle state, a sweep of the key memory one lane per
// cycle, a drain step, a commit lane step, one step per parent slot (at least one)
// and an output load.
// synchronous active-low reset clears the state, the valid bits, the highest lane and o_valid.
// a finished result waits in the output register; a new transaction is
// taken meanwhile and stalls only at its own output load.
// ----------------------------------------------------------------------------
`default_nettype none

module commit_graph_lane_assigner
    import cgla_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_first_commit,
    input  wire logic signed [KEY_W-1:0] i_commit_key,
    input  wire logic [COUNT_W-1:0]      i_parent_count,
    input  wire logic signed [KEY_W-1:0] i_parent_key_0,
    input  wire logic signed [KEY_W-1:0] i_parent_key_1,
    input  wire logic signed [KEY_W-1:0] i_parent_key_2,
    input  wire logic signed [KEY_W-1:0] i_parent_key_3,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [LANE_OUT_W-1:0]        o_commit_lane,
    output logic                         o_was_tracked,
    output logic [MASK_W-1:0]            o_pass_mask,
    output logic [PARENT_FIELDS-1:0]     o_edge_valid,
    output logic [LANE_OUT_W-1:0]        o_parent_lane_0,
    output logic [LANE_OUT_W-1:0]        o_parent_lane_1,
    output logic [LANE_OUT_W-1:0]        o_parent_lane_2,
    output logic [LANE_OUT_W-1:0]        o_parent_lane_3,
    output logic [LANE_CNT_W-1:0]        o_lane_count,
    output logic                         o_overflow
);

    localparam int LW = $clog2(LANES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_EXTRA,
        S_DONE
    } t_state;

    t_state r_state;

    logic [KEY_W-1:0]   r_ckey;
    logic [KEY_W-1:0]   r_pkey [PARENT_FIELDS];
    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] r_p;
    logic [LW:0]        r_addr;
    logic               r_rd_pend;
    logic [LW-1:0]      r_rd_lane;
    logic [LANES-1:0]   r_valid;
    logic [LANES-1:0]   r_mc;
    logic [LANES-1:0]   r_mp [PARENT_FIELDS];
    logic [LW-1:0]      r_high;
    logic [LW-1:0]      r_cl;
    logic               r_has_cl;
    logic               r_tracked;
    logic [MASK_W-1:0]  r_pass;
    logic               r_ovf;

    logic [KEY_W-1:0]   rd_data;
    logic [COUNT_W-1:0] in_cnt;

    logic               w_write;
    logic               w_free;
    logic               w_ovf;
    logic [LW-1:0]      w_lane;
    logic [KEY_W-1:0]   w_key;

    logic               c_tracked;
    logic               c_has_cl;
    logic [LW-1:0]      c_cl;
    logic [MASK_W-1:0]  c_pass;

    logic [PARENT_FIELDS-1:0]  f_edges;
    logic [LANE_OUT_W-1:0]     f_plane [PARENT_FIELDS];
    logic [7:0]                f_lc;

    function automatic logic [LW-1:0] lowest(input logic [LANES-1:0] v);
        logic [LW-1:0] idx;
        idx = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = LW'(i);
            end
        end
        return idx;
    endfunction

    cgla_key_mem #(
        .LANES (LANES),
        .LW    (LW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_waddr (w_lane),
        .i_wdata (w_key),
        .i_raddr (r_addr[LW-1:0]),
        .o_rdata (rd_data)
    );

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        if (i_parent_count > COUNT_W'(MAX_PARENTS)) begin
            in_cnt = COUNT_W'(MAX_PARENTS);
        end else begin
            in_cnt = i_parent_count;
        end
        if (in_cnt > COUNT_W'(PARENT_FIELDS)) begin
            in_cnt = COUNT_W'(PARENT_FIELDS);
        end
    end

    // commit lane lookup
    always_comb begin
        c_tracked = |r_mc;
        c_has_cl  = c_tracked | ~(&r_valid);
        c_cl      = c_tracked ? lowest(r_mc) : lowest(~r_valid);
        c_pass    = '0;
        for (int i = 0; i < LANES && i < MASK_W; i++) begin
            c_pass[i] = r_valid[i] && !(c_has_cl && c_cl == LW'(i));
        end
    end

    // table update for the current step
    always_comb begin
        w_write = 1'b0;
        w_free  = 1'b0;
        w_ovf   = 1'b0;
        w_lane  = c_cl;
        w_key   = r_pkey[0];
        unique case (r_state)
            S_COMMIT: begin
                if (!c_has_cl) begin
                    w_ovf = 1'b1;
                end else if (r_cnt == '0 || (|r_mp[0] && lowest(r_mp[0]) != c_cl)) begin
                    w_free = 1'b1;
                end else begin
                    w_write = 1'b1;
                end
            end
            S_EXTRA: begin
                w_lane = lowest(~r_valid);
                w_key  = r_pkey[r_p[1:0]];
                if (r_p < r_cnt && !(|r_mp[r_p[1:0]])) begin
                    if (&r_valid) begin
                        w_ovf = 1'b1;
                    end else begin
                        w_write = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // edges after update
    always_comb begin
        for (int p = 0; p < PARENT_FIELDS; p++) begin
            f_edges[p] = (COUNT_W'(p) < r_cnt) && (|r_mp[p]);
            f_plane[p] = f_edges[p] ? LANE_OUT_W'(lowest(r_mp[p])) : '0;
        end
        f_lc = 8'(r_high) + 8'd1;
        if (f_lc > 8'd63) begin
            f_lc = 8'd63;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_high    <= '0;
            r_rd_pend <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            r_rd_pend <= (r_state == S_SCAN);
            r_rd_lane <= r_addr[LW-1:0];
            if (r_rd_pend) begin
                r_mc[r_rd_lane] <= r_valid[r_rd_lane] && rd_data == r_ckey;
                for (int p = 0; p < PARENT_FIELDS; p++) begin
                    r_mp[p][r_rd_lane] <= r_valid[r_rd_lane] && rd_data == r_pkey[p];
                end
            end
            if (w_write) begin
                r_valid[w_lane] <= 1'b1;
                for (int p = 0; p < PARENT_FIELDS; p++) begin
                    r_mp[p][w_lane] <= (w_key == r_pkey[p]);
                end
                if (r_state == S_EXTRA && w_lane > r_high) begin
                    r_high <= w_lane;
                end
            end
            if (w_free) begin
                r_valid[w_lane] <= 1'b0;
                for (int p = 0; p < PARENT_FIELDS; p++) begin
                    r_mp[p][w_lane] <= 1'b0;
                end
            end
            if (w_ovf) begin
                r_ovf <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ckey    <= i_commit_key;
                        r_pkey[0] <= i_parent_key_0;
                        r_pkey[1] <= i_parent_key_1;
                        r_pkey[2] <= i_parent_key_2;
                        r_pkey[3] <= i_parent_key_3;
                        r_cnt     <= in_cnt;
                        r_ovf     <= 1'b0;
                        r_addr    <= '0;
                        if (i_first_commit) begin
                            r_valid <= '0;
                            r_high  <= '0;
                        end
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == (LW+1)'(LANES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_cl      <= c_cl;
                    r_has_cl  <= c_has_cl;
                    r_tracked <= c_tracked;
                    r_pass    <= c_pass;
                    if (c_has_cl && c_cl > r_high) begin
                        r_high <= c_cl;
                    end
                    r_p     <= COUNT_W'(1);
                    r_state <= S_EXTRA;
                end
                S_EXTRA: begin
                    if (r_p < r_cnt) begin
                        r_p <= r_p + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid         <= 1'b1;
                        o_commit_lane   <= r_has_cl ? LANE_OUT_W'(r_cl) : '0;
                        o_was_tracked   <= r_tracked;
                        o_pass_mask     <= r_pass;
                        o_edge_valid    <= f_edges;
                        o_parent_lane_0 <= f_plane[0];
                        o_parent_lane_1 <= f_plane[1];
                        o_parent_lane_2 <= f_plane[2];
                        o_parent_lane_3 <= f_plane[3];
                        o_lane_count    <= f_lc[LANE_CNT_W-1:0];
                        o_overflow      <= r_ovf;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/cgla_key_mem.sv
// ----------------------------------------------------------------------------
// cgla_key_mem
// lane key store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cgla_key_mem
    import cgla_pkg::*;
#(
    parameter int LANES = LANES_DEF,
    parameter int LW    = $clog2(LANES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [LW-1:0]    i_waddr,
    input  wire logic [KEY_W-1:0] i_wdata,
    input  wire logic [LW-1:0]    i_raddr,
    output logic      [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [LANES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: test/commit_graph_lane_assigner_tb.sv
// ----------------------------------------------------------------------------
// commit_graph_lane_assigner_tb
// drives commits with random and directed parent sets through the lane
// assigner, predicts every result from a local lane table and checks each
// result in order against that prediction
// ----------------------------------------------------------------------------
`default_nettype none

module commit_graph_lane_assigner_tb;
    import cgla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLANES = LANES_DEF;
    localparam int LIMIT  = 600000;

    typedef struct packed {
        logic                  first_commit;
        logic [KEY_W-1:0]      commit_key;
        logic [COUNT_W-1:0]    parent_count;
        logic [KEY_W-1:0]      pk0;
        logic [KEY_W-1:0]      pk1;
        logic [KEY_W-1:0]      pk2;
        logic [KEY_W-1:0]      pk3;
    } t_commit;

    typedef struct packed {
        logic [LANE_OUT_W-1:0]    commit_lane;
        logic                     was_tracked;
        logic [MASK_W-1:0]        pass_mask;
        logic [PARENT_FIELDS-1:0] edge_valid;
        logic [LANE_OUT_W-1:0]    pl0;
        logic [LANE_OUT_W-1:0]    pl1;
        logic [LANE_OUT_W-1:0]    pl2;
        logic [LANE_OUT_W-1:0]    pl3;
        logic [LANE_CNT_W-1:0]    lane_count;
        logic                     overflow;
    } t_lanes;

    int errors = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    class t_lane_scoreboard;
        logic [KEY_W-1:0] keys [NLANES];
        bit               live [NLANES];
        int               top_lane;
        t_lanes           pending [$];

        function new();
            foreach (live[i]) live[i] = 0;
            top_lane = 0;
        endfunction

        function int lookup(logic [KEY_W-1:0] k);
            for (int i = 0; i < NLANES; i++)
                if (live[i] && keys[i] == k) return i;
            return -1;
        endfunction

        function int free_lane();
            for (int i = 0; i < NLANES; i++)
                if (!live[i]) return i;
            return -1;
        endfunction

        function void note_commit(t_commit c);
            logic [KEY_W-1:0] pk [4];
            t_lanes r;
            int cnt, cl, oth, slot, pl;
            pk[0] = c.pk0; pk[1] = c.pk1; pk[2] = c.pk2; pk[3] = c.pk3;
            r = '0;
            cnt = (c.parent_count > 4) ? 4 : c.parent_count;
            if (c.first_commit) begin
                foreach (live[i]) live[i] = 0;
                top_lane = 0;
            end
            cl = lookup(c.commit_key);
            r.was_tracked = (cl >= 0);
            if (cl < 0) begin
                cl = free_lane();
                if (cl < 0) r.overflow = 1;
            end
            if (cl > top_lane) top_lane = cl;
            for (int i = 0; i < NLANES; i++)
                if (live[i] && i != cl) r.pass_mask[i] = 1;
            if (cl >= 0) begin
                if (cnt == 0) begin
                    live[cl] = 0;
                end else begin
                    oth = lookup(pk[0]);
                    if (oth >= 0 && oth != cl) begin
                        live[cl] = 0;
                    end else begin
                        keys[cl] = pk[0];
                        live[cl] = 1;
                    end
                end
            end
            for (int p = 1; p < cnt; p++) begin
                if (lookup(pk[p]) < 0) begin
                    slot = free_lane();
                    if (slot < 0) begin
                        r.overflow = 1;
                    end else begin
                        keys[slot] = pk[p];
                        live[slot] = 1;
                        if (slot > top_lane) top_lane = slot;
                    end
                end
            end
            for (int p = 0; p < cnt; p++) begin
                pl = lookup(pk[p]);
                if (pl >= 0) begin
                    r.edge_valid[p] = 1;
                    case (p)
                        0: r.pl0 = pl[4:0];
                        1: r.pl1 = pl[4:0];
                        2: r.pl2 = pl[4:0];
                        default: r.pl3 = pl[4:0];
                    endcase
                end
            end
            r.commit_lane = (cl >= 0) ? cl[4:0] : '0;
            r.lane_count = (top_lane + 1 > 63) ? 6'd63 : LANE_CNT_W'(top_lane + 1);
            pending = {pending, r};
        endfunction

        task check_result(t_lanes got);
            t_lanes e;
            if (pending.size() == 0) begin
                report("unexpected transaction", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.commit_lane !== e.commit_lane) report("commit_lane", got.commit_lane, e.commit_lane);
            if (got.was_tracked !== e.was_tracked) report("was_tracked", got.was_tracked, e.was_tracked);
            if (got.pass_mask !== e.pass_mask) report("pass_mask", got.pass_mask, e.pass_mask);
            if (got.edge_valid !== e.edge_valid) report("edge_valid", got.edge_valid, e.edge_valid);
            if (got.pl0 !== e.pl0) report("parent_lane_0", got.pl0, e.pl0);
            if (got.pl1 !== e.pl1) report("parent_lane_1", got.pl1, e.pl1);
            if (got.pl2 !== e.pl2) report("parent_lane_2", got.pl2, e.pl2);
            if (got.pl3 !== e.pl3) report("parent_lane_3", got.pl3, e.pl3);
            if (got.lane_count !== e.lane_count) report("lane_count", got.lane_count, e.lane_count);
            if (got.overflow !== e.overflow) report("overflow", got.overflow, e.overflow);
        endtask
    endclass

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, out_ready = 0;
    t_commit cur = '0;
    logic in_ready, out_valid;
    t_lanes res;

    always #1 clk = ~clk;

    commit_graph_lane_assigner u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_first_commit(cur.first_commit), .i_commit_key(cur.commit_key),
        .i_parent_count(cur.parent_count),
        .i_parent_key_0(cur.pk0), .i_parent_key_1(cur.pk1),
        .i_parent_key_2(cur.pk2), .i_parent_key_3(cur.pk3),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_commit_lane(res.commit_lane), .o_was_tracked(res.was_tracked),
        .o_pass_mask(res.pass_mask), .o_edge_valid(res.edge_valid),
        .o_parent_lane_0(res.pl0), .o_parent_lane_1(res.pl1),
        .o_parent_lane_2(res.pl2), .o_parent_lane_3(res.pl3),
        .o_lane_count(res.lane_count), .o_overflow(res.overflow)
    );

    t_lane_scoreboard sb = new();
    int send_idle = 0, recv_idle = 0;
    int hold_off = 0;
    int cycles = 0;

    // keys of recent parents (first two parent keys), so sequences revisit live lanes
    logic [KEY_W-1:0] key_pool [$];

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && out_valid && out_ready) sb.check_result(res);
    end

    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off--;
            out_ready <= 0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(input t_commit c);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
        cur = c;
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        sb.note_commit(c);
        @(negedge clk);
        in_valid = 0;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(99) < 70)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        return rand_key();
    endfunction

    function automatic t_commit rand_commit(input bit first);
        t_commit c;
        c.first_commit = first;
        c.commit_key = pick_key();
        c.parent_count = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                  : 3'($urandom_range(2));
        if ($urandom_range(9) == 0) c.parent_count = 4;
        c.pk0 = pick_key();
        c.pk1 = ($urandom_range(3) == 0) ? pick_key() : rand_key();
        c.pk2 = rand_key();
        c.pk3 = pick_key();
        return c;
    endfunction

    task automatic run_random(input int n);
        t_commit c;
        for (int i = 0; i < n; i++) begin
            c = rand_commit($urandom_range(59) == 0);
            send(c);
            key_pool = {key_pool, c.pk0};
            key_pool = {key_pool, c.pk1};
            if (key_pool.size() > 40) void'(key_pool.pop_front());
        end
    endtask

    task automatic drain();
        while (sb.pending.size() > 0) @(negedge clk);
    endtask

    t_commit d;

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: field extremes, root, merge, duplicates, large count
        d = '{1'b1, 64'h8000_0000_0000_0000, 3'd1, 64'h7fff_ffff_ffff_ffff, 0, 0, 0};
        send(d);
        d = '{1'b0, 64'h7fff_ffff_ffff_ffff, 3'd4, 64'hffff_ffff_ffff_ffff, 64'h0,
              64'h8000_0000_0000_0000, 64'h0};
        send(d);
        d = '{1'b0, 64'h0, 3'd7, 64'h1, 64'h2, 64'h3, 64'h4};
        send(d);
        d = '{1'b0, 64'h1, 3'd2, 64'h2, 64'h5, 0, 0};
        send(d);
        d = '{1'b0, 64'hffff_ffff_ffff_ffff, 3'd0, 0, 0, 0, 0};
        send(d);
        d = '{1'b0, 64'h2, 3'd6, 64'h3, 64'h3, 64'h3, 64'h9};
        send(d);
        // fill the table to force commit and parent overflow
        d = '{1'b1, 64'h100, 3'd4, 64'h200, 64'h300, 64'h400, 64'h500};
        send(d);
        for (int i = 0; i < 12; i++) begin
            d = '{1'b0, 64'h1000 + i, 3'd4, 64'h2000 + i, 64'h3000 + i,
                  64'h4000 + i, 64'h5000 + i};
            send(d);
        end
        d = '{1'b0, 64'hdead, 3'd3, 64'h300, 64'hbeef, 64'hcafe, 0};
        send(d);
        d = '{1'b0, 64'h400, 3'd0, 0, 0, 0, 0};
        send(d);
        d = '{1'b1, 64'h55, 3'd5, 64'h55, 64'h55, 64'h66, 64'h66};
        send(d);

        send_idle = 23; recv_idle = 55;
        run_random(300);
        // long receiver stall while the sender keeps going
        hold_off = 400;
        run_random(20);
        // sender pause until everything is back
        drain();
        send_idle = 55; recv_idle = 23;
        run_random(300);
        send_idle = 0; recv_idle = 0;
        run_random(300);

        drain();
        repeat (200) @(negedge clk);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/cgla_pkg.sv
rtl/cgla_key_mem.sv
rtl/commit_graph_lane_assigner.sv
test/commit_graph_lane_assigner_tb.sv
